[rtl/core/kch_pkg.sv]
// shared constants and types of the k-mer count histogram
`timescale 1ns / 1ps
`default_nettype none

package kch_pkg;

  localparam int unsigned MAX_K_DEF      = 8;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned KLEN_W   = 4;
  localparam int unsigned RUN_W    = 4;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_W  = APB_AW - 2;

  localparam logic [REG_W-1:0]  REG_KMER_LENGTH = '0;
  localparam logic [KLEN_W-1:0] KLEN_RST        = 4'd1;
  localparam logic [RUN_W-1:0]  RUN_MAX         = 4'hF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_START = 2'd1,
    ACT_READ  = 2'd2
  } kch_action_e;

  // what the update stage does to the addressed counter
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INC  = 2'd1,
    OP_CLR  = 2'd2
  } kch_op_e;

  typedef struct packed {
    logic    valid;
    kch_op_e op;
  } kch_req_t;

endpackage

`default_nettype wire

[rtl/core/kch_item_if.sv]
// input item channel: action, base byte and read index
`timescale 1ns / 1ps
`default_nettype none

interface kch_item_if
  import kch_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   base_char;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, output action, output base_char, output read_index,
                  input ready);
  modport sink   (input valid, input action, input base_char, input read_index,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/kch_result_if.sv]
// result channel: counted flag, k-mer index and counter value
`timescale 1ns / 1ps
`default_nettype none

interface kch_result_if
  import kch_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               counted;
  logic [INDEX_W-1:0] kmer_index;
  logic [VALUE_W-1:0] count_value;

  modport source (output valid, output counted, output kmer_index, output count_value,
                  input ready);
  modport sink   (input valid, input counted, input kmer_index, input count_value,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/kmer_count_histogram_unit.sv]
// k-mer count histogram: top level with register port, window, counter ram and update
// each item is held in the update stage register, then in the result register
// throughput: one item per cycle while results are taken; back-to-back updates of one
//   counter go through a one-entry forwarding register in front of the ram read port
// reset: window, run length and kmer_length (to 1) reset at once; then a clearing
//   sweep writes zero to all 4^MAX_K counters, one per cycle, during which no item is taken;
//   register writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module kmer_count_histogram_unit
  import kch_pkg::*;
#(
  parameter int unsigned MAX_K      = MAX_K_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kch_item_if.sink          item_i,
  kch_result_if.source      result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = 2 * MAX_K;
  localparam int unsigned DEPTH = 32'd1 << IDX_W;

  logic [KLEN_W-1:0]     kmer_length_q, kmer_length_d;
  logic [REG_W-1:0]      reg_idx;
  logic                  reg_we;
  logic                  accept, upd_ready, busy;
  kch_req_t              req;
  logic [IDX_W-1:0]      addr, waddr;
  logic                  we;
  logic [COUNT_BITS-1:0] wdata, rdata;

  // register port
  assign pready        = 1'b1;
  assign reg_idx       = paddr[APB_AW-1:2];
  assign reg_we        = psel && penable && pwrite && (reg_idx == REG_KMER_LENGTH);
  assign kmer_length_d = pwdata[KLEN_W-1:0];
  assign prdata        = (reg_idx == REG_KMER_LENGTH) ? APB_DW'(kmer_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KLEN_RST;
    end else if (reg_we) begin
      kmer_length_q <= kmer_length_d;
    end
  end

  assign item_i.ready = upd_ready;
  assign accept       = item_i.valid && upd_ready;

  kch_window #(
    .MAX_K (MAX_K)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (item_i.action),
    .base_char_i   (item_i.base_char),
    .read_index_i  (item_i.read_index),
    .kmer_length_i (kmer_length_q),
    .req_o         (req),
    .addr_o        (addr)
  );

  kch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  kch_update #(
    .MAX_K      (MAX_K),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .addr_i        (addr),
    .rdata_i       (rdata),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .ready_o       (upd_ready),
    .busy_o        (busy),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .counted_o     (result_o.counted),
    .kmer_index_o  (result_o.kmer_index),
    .count_value_o (result_o.count_value)
  );

  a_clear_blocks_items : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !item_i.ready)
    else $error("item taken during clearing sweep");

  a_clear_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_o.valid)
    else $error("result offered during clearing sweep");

  a_count_read_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.counted) |-> (result_o.count_value == '0))
    else $error("counted result carries a counter value");

  a_uncounted_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.counted) |-> (result_o.kmer_index == '0))
    else $error("index reported without a count");

endmodule

`default_nettype wire

[rtl/core/kch_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module kch_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/kch_window.sv]
// rolling k-mer window, base decode and counter address selection
`timescale 1ns / 1ps
`default_nettype none

module kch_window
  import kch_pkg::*;
#(
  parameter  int unsigned MAX_K = MAX_K_DEF,
  localparam int unsigned IDX_W = 2 * MAX_K
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CHAR_W-1:0]   base_char_i,
  input  logic [INDEX_W-1:0]  read_index_i,
  input  logic [KLEN_W-1:0]   kmer_length_i,
  output kch_req_t            req_o,
  output logic [IDX_W-1:0]    addr_o
);

  logic [IDX_W-1:0] win_q, win_d;
  logic [IDX_W-1:0] shifted, kmask;
  logic [RUN_W-1:0] run_q, run_d, run_inc;
  logic             base_ok;
  logic [1:0]       base_code;
  logic             len_ok, hit;
  kch_op_e          op;

  always_comb begin
    base_ok   = 1'b1;
    base_code = 2'd0;
    case (base_char_i)
      "A", "a": base_code = 2'd0;
      "T", "t": base_code = 2'd1;
      "G", "g": base_code = 2'd2;
      "C", "c": base_code = 2'd3;
      default:  base_ok   = 1'b0;
    endcase
  end

  always_comb begin
    shifted = (win_q << 2) | IDX_W'(base_code);
    run_inc = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
    // two mask bits per base of the configured length
    for (int b = 0; b < int'(IDX_W); b++) begin
      kmask[b] = ((b >> 1) < int'(kmer_length_i));
    end
    len_ok = (kmer_length_i != '0) && (int'(kmer_length_i) <= int'(MAX_K));
    hit    = len_ok && (run_inc >= kmer_length_i);

    win_d  = win_q;
    run_d  = run_q;
    op     = OP_NONE;
    addr_o = shifted & kmask;
    case (action_i)
      ACT_PUSH: begin
        if (base_ok) begin
          win_d = shifted;
          run_d = run_inc;
          if (hit) begin
            op = OP_INC;
          end
        end else begin
          win_d = '0;
          run_d = '0;
        end
      end
      ACT_START: begin
        win_d = '0;
        run_d = '0;
      end
      ACT_READ: begin
        op     = OP_CLR;
        addr_o = IDX_W'(read_index_i);
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      run_q <= '0;
    end else if (accept_i) begin
      win_q <= win_d;
      run_q <= run_d;
    end
  end

  assign req_o.valid = accept_i;
  assign req_o.op    = op;

endmodule

`default_nettype wire

[rtl/core/kch_update.sv]
// counter read-modify-write stage with forwarding, clearing sweep and result register
`timescale 1ns / 1ps
`default_nettype none

module kch_update
  import kch_pkg::*;
#(
  parameter  int unsigned MAX_K      = MAX_K_DEF,
  parameter  int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned IDX_W      = 2 * MAX_K
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kch_req_t              req_i,
  input  logic [IDX_W-1:0]      addr_i,
  input  logic [COUNT_BITS-1:0] rdata_i,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [COUNT_BITS-1:0] wdata_o,
  output logic                  ready_o,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  counted_o,
  output logic [INDEX_W-1:0]    kmer_index_o,
  output logic [VALUE_W-1:0]    count_value_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } kch_state_e;

  kch_state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  logic                  s1_valid_q;
  kch_op_e               s1_op_q;
  logic [IDX_W-1:0]      s1_addr_q;

  logic                  fwd_valid_q;
  logic [IDX_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  out_valid_q;
  logic                  counted_q;
  logic [INDEX_W-1:0]    kidx_q;
  logic [VALUE_W-1:0]    cval_q;

  logic                  adv, s1_go, run_we;
  logic [COUNT_BITS-1:0] old_val, bumped;

  assign adv     = !out_valid_q || out_ready_i;
  assign s1_go   = s1_valid_q && adv;
  assign busy_o  = (state_q == ST_CLEAR);
  assign ready_o = (state_q == ST_RUN) && (!s1_valid_q || adv);

  // the ram read raced the previous write when the addresses match
  assign old_val = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata_i;
  assign bumped  = (old_val == '1) ? old_val : old_val + COUNT_BITS'(1);
  assign run_we  = s1_go && (s1_op_q != OP_NONE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    we_o    = run_we;
    waddr_o = s1_addr_q;
    wdata_o = (s1_op_q == OP_INC) ? bumped : '0;
    case (state_q)
      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = '0;
        clr_d   = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (req_i.valid) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (run_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_op_q   <= req_i.op;
      s1_addr_q <= addr_i;
    end
    if (run_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wdata_o;
    end
    if (s1_go) begin
      counted_q <= (s1_op_q == OP_INC);
      kidx_q    <= (s1_op_q == OP_INC) ? INDEX_W'(s1_addr_q) : '0;
      cval_q    <= (s1_op_q == OP_CLR) ? VALUE_W'(old_val) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign counted_o     = counted_q;
  assign kmer_index_o  = kidx_q;
  assign count_value_o = cval_q;

endmodule

`default_nettype wire

[dv/kmer_count_histogram_unit_tb.sv]
// testbench for the k-mer count histogram unit: random and directed items against a predictor
`timescale 1ns / 1ps

module kmer_count_histogram_unit_tb;
  import kch_pkg::*;

  localparam int unsigned  CLK_PERIOD     = 20;
  localparam int unsigned  RESET_CYCLES   = 12;
  localparam int unsigned  HIST_DEPTH     = 1 << (2 * MAX_K_DEF);
  localparam int unsigned  IDLE_PCT       = 26;
  localparam int unsigned  PHASE_ITEMS    = 100;
  localparam int unsigned  HOLD_AFTER     = 500;
  localparam int unsigned  HOLD_CYCLES    = 300;
  localparam int unsigned  DRAIN_CYCLES   = 4;
  localparam int unsigned  TAIL_CYCLES    = 10;
  localparam int unsigned  QUIET_LIMIT    = 200000;
  localparam int unsigned  MAX_PRINTS     = 30;
  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
  localparam logic [APB_AW-1:0]   ADDR_KLEN    = {REG_KMER_LENGTH, 2'b00};
  localparam logic [APB_AW-1:0]   ADDR_UNUSED  = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   base_char;
    logic [INDEX_W-1:0]  read_index;
  } kmer_item_t;

  typedef struct packed {
    logic               counted;
    logic [INDEX_W-1:0] kmer_index;
    logic [VALUE_W-1:0] count_value;
  } kmer_result_t;

  // histogram predictor and store of the results still to come
  class kmer_hist_scoreboard;
    bit [VALUE_W-1:0] hist [HIST_DEPTH];
    bit [INDEX_W-1:0] window;
    bit [RUN_W-1:0]   run_len;
    bit [KLEN_W-1:0]  klen;
    bit [INDEX_W-1:0] last_index;
    kmer_result_t     result_q[$];
    int unsigned      errors;

    function new();
      klen = KLEN_RST;
    endfunction

    function int base_code(logic [CHAR_W-1:0] c);
      case (c)
        "A", "a": return 0;
        "T", "t": return 1;
        "G", "g": return 2;
        "C", "c": return 3;
        default:  return -1;
      endcase
    endfunction

    function int unsigned outstanding();
      return result_q.size();
    endfunction

    function void count_item(kmer_item_t it);
      kmer_result_t       res;
      int                 code;
      int                 k;
      bit [INDEX_W-1:0]   idx;
      res = '0;
      k   = int'(klen);
      case (it.action)
        ACT_PUSH: begin
          code = base_code(it.base_char);
          if (code < 0) begin
            window  = '0;
            run_len = '0;
          end else begin
            window = {window[INDEX_W-3:0], 2'(code)};
            if (run_len != RUN_MAX) run_len++;
            if (k >= 1 && k <= MAX_K_DEF && run_len >= k) begin
              idx = window & ({INDEX_W{1'b1}} >> (INDEX_W - 2 * k));
              if (hist[idx] != '1) hist[idx]++;
              res.counted    = 1'b1;
              res.kmer_index = idx;
              last_index     = idx;
            end
          end
        end
        ACT_START: begin
          window  = '0;
          run_len = '0;
        end
        ACT_READ: begin
          res.count_value      = hist[it.read_index];
          hist[it.read_index]  = '0;
        end
        default: ;
      endcase
      result_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(kmer_result_t got);
      kmer_result_t want;
      if (result_q.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = result_q.pop_front();
      if (got.counted !== want.counted)
        report($sformatf("counted %0b, expected %0b", got.counted, want.counted));
      if (got.kmer_index !== want.kmer_index)
        report($sformatf("kmer_index %0h, expected %0h", got.kmer_index, want.kmer_index));
      if (got.count_value !== want.count_value)
        report($sformatf("count_value %0h, expected %0h", got.count_value, want.count_value));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  kch_item_if   item_if ();
  kch_result_if result_if ();

  kmer_hist_scoreboard hist_sb = new();

  bit          idle_en = 1'b1;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned xfer_count;

  kmer_count_histogram_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // result side: random stalls plus one long hold-off so the block backs up
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) begin
      hist_sb.check_result({result_if.counted, result_if.kmer_index,
                            result_if.count_value});
      xfer_count++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    int unsigned seen;
    quiet = 0;
    seen  = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (xfer_count != seen) begin
        seen  = xfer_count;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("kmer_count_histogram_unit_tb failed");
    $finish;
  end

  function automatic kmer_item_t make_item(logic [ACTION_W-1:0] action,
                                           logic [CHAR_W-1:0] c,
                                           logic [INDEX_W-1:0] idx);
    kmer_item_t it;
    it.action     = action;
    it.base_char  = c;
    it.read_index = idx;
    return it;
  endfunction

  task automatic send_item(kmer_item_t it);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.action     <= it.action;
    item_if.base_char  <= it.base_char;
    item_if.read_index <= it.read_index;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
    hist_sb.count_item(it);
    items_sent++;
    xfer_count++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (hist_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_KLEN) hist_sb.klen = data[KLEN_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_klen();
    logic [APB_DW-1:0] data;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_KLEN;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== APB_DW'(hist_sb.klen))
      hist_sb.report($sformatf("kmer_length read %0h, expected %0h", data, hist_sb.klen));
  endtask

  function automatic kmer_item_t random_item();
    logic [CHAR_W-1:0]  letters [8] = '{"A", "T", "G", "C", "a", "t", "g", "c"};
    int unsigned        pick;
    int unsigned        k;
    logic [CHAR_W-1:0]  c;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(99);
    k    = 32'(hist_sb.klen);
    c    = CHAR_W'($urandom_range(255));
    idx  = INDEX_W'($urandom_range(65535));
    if (pick < 72) begin
      // mostly bases so the window fills, now and then a stray byte
      if ($urandom_range(99) < 90) c = letters[$urandom_range(7)];
      return make_item(ACT_PUSH, c, idx);
    end
    if (pick < 78) return make_item(ACT_START, c, idx);
    if (pick < 95) begin
      pick = $urandom_range(99);
      if (pick < 60)
        idx = hist_sb.last_index;
      else if (pick < 85 && k >= 1 && k <= MAX_K_DEF)
        idx = INDEX_W'($urandom_range((1 << (2 * k)) - 1));
      return make_item(ACT_READ, c, idx);
    end
    return make_item(ACT_UNUSED, c, idx);
  endfunction

  initial begin
    int unsigned klen_plan [11];
    string       seq;
    klen_plan = '{8, 2, 0, 3, 15, 1, 4, 9, 6, 5, 7};
    item_if.valid      = 1'b0;
    item_if.action     = ACT_PUSH;
    item_if.base_char  = '0;
    item_if.read_index = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_klen();

    // length one after reset: every base counts, both cases
    seq = "ATGCatgc";
    foreach (seq[i]) send_item(make_item(ACT_PUSH, seq[i], 16'h0000));
    send_item(make_item(ACT_PUSH, "$", 16'hFFFF));
    send_item(make_item(ACT_PUSH, 8'h00, 16'h0000));
    send_item(make_item(ACT_PUSH, 8'hFF, 16'hFFFF));
    send_item(make_item(ACT_START, "A", 16'h1234));
    send_item(make_item(ACT_READ, "C", 16'h0000));
    send_item(make_item(ACT_READ, 8'hFF, 16'h0003));
    send_item(make_item(ACT_READ, "G", 16'h0000));
    send_item(make_item(ACT_READ, 8'h00, 16'hFFFF));
    send_item(make_item(ACT_UNUSED, "A", 16'h0001));
    drain();

    // widest k-mer, counted only on the eighth base
    apb_write(ADDR_KLEN, {28'($urandom_range(32'h0FFF_FFFF)), 4'd8});
    check_klen();
    seq = "ACGTACGT";
    foreach (seq[i]) send_item(make_item(ACT_PUSH, seq[i], 16'h0000));
    drain();

    // a write beyond the register list leaves kmer_length alone
    apb_write(ADDR_UNUSED, 32'h0000_0003);
    check_klen();

    foreach (klen_plan[p]) begin
      apb_write(ADDR_KLEN, {28'($urandom_range(32'h0FFF_FFFF)), 4'(klen_plan[p])});
      check_klen();
      idle_en = (p != 3);
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end
    idle_en = 1'b1;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (hist_sb.errors == 0 && hist_sb.outstanding() == 0) begin
      $display("kmer_count_histogram_unit_tb passed");
    end else begin
      $display("kmer_count_histogram_unit_tb failed");
    end
    $finish;
  end

endmodule
